// File: hw/rtl/ipnc_pkg.sv
`default_nettype none
package ipnc_pkg;

  localparam int ENTRIES = 8;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SLOT_W  = 6;
  localparam int IP_W    = 32;
  localparam int HW_W    = 48;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  typedef struct packed {
    logic            cmd;
    logic [IP_W-1:0] net_addr;
    logic [HW_W-1:0] hw_address;
  } in_t;

  typedef struct packed {
    logic              hit;
    logic [HW_W-1:0]   hw_address_out;
    logic [SLOT_W-1:0] slot;
  } out_t;

  // one slot compare result
  typedef struct packed {
    logic match;
    logic free;
  } cmp_t;

  // table write request
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [IP_W-1:0]  ip;
    logic [HW_W-1:0]  hw;
  } wr_t;

endpackage
`default_nettype wire

// File: hw/rtl/ipv4_neighbour_cache.sv
// channel | ports                          | beat
// input   | in_valid, in_ready, in_data    | cmd, net_addr, hw_address
// result  | out_valid, out_ready, out_data | hit, hw_address_out, slot
//
// a lookup miss scans every slot (one slot per cycle through the shared compare
// unit) and registers its result; an update adds the ST_WRITE state, a lookup
// hit adds ST_READ and ST_FIN (hw table read); address 0 gives its result from
// ST_IDLE without a scan; in_ready returns the cycle after the result beat
// rst_n (sync, active low) clears all valid bits, so every slot is free
// in_ready is low while a beat is in work or a result waits on out_ready
`default_nettype none
module ipv4_neighbour_cache (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire ipnc_pkg::in_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output ipnc_pkg::out_t out_data
);

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [ST_W-1:0] ST_SCAN  = 3'd1;
  localparam logic [ST_W-1:0] ST_WRITE = 3'd2;
  localparam logic [ST_W-1:0] ST_READ  = 3'd3;
  localparam logic [ST_W-1:0] ST_FIN   = 3'd4;

  localparam logic [ipnc_pkg::IDX_W-1:0] LAST_IDX =
    ipnc_pkg::IDX_W'(ipnc_pkg::ENTRIES - 1);

  logic [ST_W-1:0]            state_r, state_nxt;
  ipnc_pkg::in_t              item_r, item_nxt;
  logic [ipnc_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                       mfound_r, mfound_nxt;
  logic [ipnc_pkg::IDX_W-1:0] midx_r, midx_nxt;
  logic                       ffound_r, ffound_nxt;
  logic [ipnc_pkg::IDX_W-1:0] fidx_r, fidx_nxt;
  logic                       out_valid_r, out_valid_nxt;
  ipnc_pkg::out_t             out_r, out_nxt;

  logic [ipnc_pkg::IP_W-1:0]  scan_ip;
  logic                       scan_valid;
  logic [ipnc_pkg::HW_W-1:0]  hw_rd_data;
  ipnc_pkg::cmp_t             cmp;
  ipnc_pkg::wr_t              wr;
  logic [ipnc_pkg::IDX_W-1:0] target;

  // scan read address is idx_nxt, registered in the table, so slot idx_r is on scan_ip
  ipnc_table u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .scan_idx   (idx_nxt),
    .scan_ip    (scan_ip),
    .scan_valid (scan_valid),
    .hw_rd_idx  (midx_r),
    .hw_rd_data (hw_rd_data),
    .wr         (wr)
  );

  // shared compare unit, one slot per cycle
  ipnc_cmp u_cmp (
    .key         (item_r.net_addr),
    .entry_ip    (scan_ip),
    .entry_valid (scan_valid),
    .res         (cmp)
  );

  assign in_ready  = (state_r == ST_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // existing slot first, then lowest free slot, else evict slot 0
  assign target = mfound_r ? midx_r : (ffound_r ? fidx_r : '0);

  always_comb begin
    wr.en  = (state_r == ST_WRITE);
    wr.idx = target;
    wr.ip  = item_r.net_addr;
    wr.hw  = item_r.hw_address;
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    idx_nxt       = idx_r;
    mfound_nxt    = mfound_r;
    midx_nxt      = midx_r;
    ffound_nxt    = ffound_r;
    fidx_nxt      = fidx_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          item_nxt   = in_data;
          idx_nxt    = '0;
          mfound_nxt = 1'b0;
          ffound_nxt = 1'b0;
          if (in_data.net_addr == '0) begin
            // reserved address: miss, no table change
            out_nxt       = '0;
            out_valid_nxt = 1'b1;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (!mfound_r && cmp.match) begin
          mfound_nxt = 1'b1;
          midx_nxt   = idx_r;
        end
        if (!ffound_r && cmp.free) begin
          ffound_nxt = 1'b1;
          fidx_nxt   = idx_r;
        end
        if (idx_r == LAST_IDX) begin
          if (item_r.cmd == ipnc_pkg::CMD_UPDATE) begin
            state_nxt = ST_WRITE;
          end else if (mfound_nxt) begin
            state_nxt = ST_READ;
          end else begin
            out_nxt       = '0;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      ST_WRITE: begin
        out_nxt.hit            = mfound_r;
        out_nxt.hw_address_out = '0;
        out_nxt.slot           = ipnc_pkg::SLOT_W'(target);
        out_valid_nxt          = 1'b1;
        state_nxt              = ST_IDLE;
      end

      // hw table read data registers at the end of this cycle
      ST_READ: begin
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        out_nxt.hit            = 1'b1;
        out_nxt.hw_address_out = hw_rd_data;
        out_nxt.slot           = ipnc_pkg::SLOT_W'(midx_r);
        out_valid_nxt          = 1'b1;
        state_nxt              = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      mfound_r    <= 1'b0;
      ffound_r    <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      mfound_r    <= mfound_nxt;
      ffound_r    <= ffound_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    midx_r <= midx_nxt;
    fidx_r <= fidx_nxt;
    out_r  <= out_nxt;
  end

endmodule
`default_nettype wire

// File: hw/rtl/ipnc_cmp.sv
`default_nettype none
module ipnc_cmp (
  input  wire logic [ipnc_pkg::IP_W-1:0] key,
  input  wire logic [ipnc_pkg::IP_W-1:0] entry_ip,
  input  wire logic                      entry_valid,
  output ipnc_pkg::cmp_t                 res
);

  // a valid slot always holds a nonzero address
  always_comb begin
    res.match = entry_valid && (entry_ip == key);
    res.free  = !entry_valid;
  end

endmodule
`default_nettype wire

// File: hw/rtl/ipnc_table.sv
`default_nettype none
module ipnc_table (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [ipnc_pkg::IDX_W-1:0] scan_idx,
  output logic      [ipnc_pkg::IP_W-1:0]  scan_ip,
  output logic                            scan_valid,
  input  wire logic [ipnc_pkg::IDX_W-1:0] hw_rd_idx,
  output logic      [ipnc_pkg::HW_W-1:0]  hw_rd_data,
  input  wire ipnc_pkg::wr_t              wr
);

  logic [ipnc_pkg::ENTRIES-1:0] valid_r;
  logic [ipnc_pkg::IP_W-1:0]    ip_mem [ipnc_pkg::ENTRIES];
  logic [ipnc_pkg::HW_W-1:0]    hw_mem [ipnc_pkg::ENTRIES];
  logic [ipnc_pkg::HW_W-1:0]    hw_rd_r;
  logic [ipnc_pkg::IP_W-1:0]    scan_ip_r;
  logic                         scan_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      scan_valid_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.idx] <= 1'b1;
      end
      scan_valid_r <= valid_r[scan_idx];
    end
  end

  // registered reads, data shows up the cycle after the address
  always_ff @(posedge clk) begin
    if (wr.en) begin
      ip_mem[wr.idx] <= wr.ip;
      hw_mem[wr.idx] <= wr.hw;
    end
    scan_ip_r <= ip_mem[scan_idx];
    hw_rd_r   <= hw_mem[hw_rd_idx];
  end

  assign scan_valid = scan_valid_r;
  assign scan_ip    = scan_valid_r ? scan_ip_r : '0;
  assign hw_rd_data = hw_rd_r;

endmodule
`default_nettype wire
